// ===== rtl/core/beof_pkg.sv =====
// Shared types and constants for the band envelope onset follower.
`timescale 1ns / 1ps
package beof_pkg;
   typedef struct packed {
      logic [19:0] bin_value;
      logic        last_bin;
      logic [31:0] timestamp;
      logic        jumped;
   } req_word_type;

   typedef struct packed {
      logic [16:0] drive;
      logic [16:0] instant;
   } rsp_word_type;

   localparam logic [2:0] REG_BAND_START  = 3'd0;
   localparam logic [2:0] REG_BAND_END    = 3'd1;
   localparam logic [2:0] REG_ONSET_MODE  = 3'd2;
   localparam logic [2:0] REG_PRIME_SIL   = 3'd3;
   localparam logic [2:0] REG_LEVEL_RET   = 3'd4;
   localparam logic [2:0] REG_BASE_RET    = 3'd5;
   localparam logic [2:0] REG_ONSET_RET   = 3'd6;
   localparam logic [2:0] REG_ONSET_GAIN  = 3'd7;

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ROOT_LOAD,   // latch bin, start root
      OP_ROOT_STEP,   // one root bit
      OP_ROOT_ACC,    // add root to sum
      OP_DIV_LOAD,    // start mean divide
      OP_DIV_STEP,    // one quotient bit
      OP_PRIME,       // clamp x, prime, compute elapsed
      OP_POW_LOAD,    // start three powers
      OP_POW_MUL,     // multiply result by base (one of three)
      OP_POW_SQR,     // square base (one of three)
      OP_UPD_MUL,     // product for tracker update (one of three)
      OP_UPD_GAIN,    // flux times gain
      OP_FINISH       // commit trackers, form result
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic root_done;
      logic div_done;
      logic pow_done;
      logic in_range;
      logic last_bin;
   } status_type;
endpackage

// ===== rtl/core/band_envelope_onset_follower_core.sv =====
// Top level of the band envelope onset follower.
`timescale 1ns / 1ps
// Takes one spectrum bin word at a time. Each bin runs through a bit-serial
// square root of 18 steps before the next word is accepted. The last bin of a
// frame adds a restoring divide (one quotient bit per cycle, 18 plus
// clog2(MAX_BINS+1) steps, 29 by default), three retain powers by a shared
// rounded multiplier (a multiply and a square per power for each exponent bit)
// and the tracker update, then holds the result word until rsp_stall drops.
// One word is in flight at a time. Configuration writes are always ready.
module band_envelope_onset_follower_core #(
   parameter int MAX_BINS    = 1024,
   parameter int MAX_ELAPSED = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  beof_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output beof_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_data
);
   import beof_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [9:0]  band_start_bin, band_end_bin;
   logic        onset_mode, prime_from_silence;
   logic [15:0] level_retain, baseline_retain, onset_retain, onset_gain;

   beof_csr u_csr (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .band_start_bin, .band_end_bin, .onset_mode, .prime_from_silence,
      .level_retain, .baseline_retain, .onset_retain, .onset_gain
   );

   beof_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   beof_datapath #(.MAX_BINS(MAX_BINS), .MAX_ELAPSED(MAX_ELAPSED)) u_datapath (
      .clock, .reset, .req_word, .cmd, .status,
      .band_start_bin, .band_end_bin, .onset_mode, .prime_from_silence,
      .level_retain, .baseline_retain, .onset_retain, .onset_gain, .rsp_word
   );
endmodule

// ===== rtl/core/beof_datapath.sv =====
// Datapath: bin root, band sum, mean divide, powers and tracker update.
`timescale 1ns / 1ps
module beof_datapath #(
   parameter int MAX_BINS    = 1024,
   parameter int MAX_ELAPSED = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  beof_pkg::req_word_type req_word,
   input  beof_pkg::cmd_type      cmd,
   output beof_pkg::status_type   status,
   input  logic [9:0]             band_start_bin,
   input  logic [9:0]             band_end_bin,
   input  logic                   onset_mode,
   input  logic                   prime_from_silence,
   input  logic [15:0]            level_retain,
   input  logic [15:0]            baseline_retain,
   input  logic [15:0]            onset_retain,
   input  logic [15:0]            onset_gain,
   output beof_pkg::rsp_word_type rsp_word
);
   import beof_pkg::*;

   localparam int PW = $clog2(MAX_BINS + 1);
   localparam int CW = PW + 1;
   localparam int SW = 18 + PW;
   localparam int EW = $clog2(MAX_ELAPSED + 1);
   localparam int BW = (PW > 10) ? PW : 10;

   // item latched
   logic        last_ff, jumped_ff;
   logic [31:0] now_ff;

   // frame accumulation
   logic [PW-1:0] pos_ff;
   logic [SW-1:0] sum_ff;
   logic [CW-1:0] cnt_ff;

   // root unit
   logic [35:0] rv_ff, rres_ff, rbit_ff;

   // divider
   logic [SW-1:0] dq_ff, drem_ff;
   logic [5:0]    dcnt_ff;

   // trackers
   logic        primed_ff;
   logic [31:0] last_time_ff;
   logic [16:0] level_ff, base_ff, env_ff, x_ff;
   logic [EW-1:0] e_ff;
   logic [16:0] pres_ff [3];
   logic [16:0] pbase_ff [3];
   logic [16:0] prod_ff [3];
   logic [24:0] grown_ff;
   rsp_word_type rsp_ff;

   logic in_range;
   assign in_range = (BW'(pos_ff) >= BW'(band_start_bin)) &&
                     (BW'(pos_ff) <= BW'(band_end_bin)) &&
                     (pos_ff < PW'(MAX_BINS));

   assign status.in_range  = in_range;
   assign status.last_bin  = last_ff;
   assign status.root_done = (rbit_ff == '0);
   assign status.div_done  = (dcnt_ff == '0);
   assign status.pow_done  = (e_ff == '0);
   assign rsp_word = rsp_ff;

   function automatic logic [16:0] rmul(input logic [16:0] a, input logic [16:0] b);
      logic [33:0] p;
      p = a * b + 34'd32768;
      return p[32:16];
   endfunction

   logic [16:0] pa, pb, pr;
   always_comb begin
      pa = pres_ff[cmd.sel];
      pb = pbase_ff[cmd.sel];
      case (cmd.op)
         OP_POW_SQR: pa = pbase_ff[cmd.sel];
         OP_UPD_MUL: begin
            case (cmd.sel)
               2'd0: pa = level_ff - x_ff;
               2'd1: pa = (base_ff >= x_ff) ? base_ff - x_ff : x_ff - base_ff;
               default: pa = env_ff;
            endcase
         end
         default: ;
      endcase
      pr = rmul(pa, pb);
   end

   logic [35:0] rtry;
   logic [SW:0] dtry;
   logic [31:0] el;
   logic [16:0] xc, flux;
   logic [16:0] lvl_n, base_n, env_n, grown_c;
   assign rtry = rres_ff + rbit_ff;
   assign dtry = {drem_ff, dq_ff[SW-1]} - {{(SW-CW+1){1'b0}}, cnt_ff};

   always_comb begin
      flux = (x_ff > base_ff) ? x_ff - base_ff : '0;
      grown_c = (grown_ff > 25'd65536) ? ONE_Q16 : grown_ff[16:0];
      lvl_n = (x_ff >= level_ff) ? x_ff : x_ff + prod_ff[0];
      base_n = (base_ff >= x_ff) ? x_ff + prod_ff[1] : x_ff - prod_ff[1];
      env_n = (grown_c > prod_ff[2]) ? grown_c : prod_ff[2];
      xc = (cnt_ff == '0) ? '0 :
           ((dq_ff > SW'(65536)) ? ONE_Q16 : dq_ff[16:0]);
      el = now_ff - last_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; sum_ff <= '0; cnt_ff <= '0;
         primed_ff <= 1'b0; last_time_ff <= '0;
         level_ff <= '0; base_ff <= '0; env_ff <= '0;
         rbit_ff <= '0; dcnt_ff <= '0; e_ff <= '0;
      end else begin
         case (cmd.op)
            OP_ROOT_LOAD: begin
               last_ff <= req_word.last_bin;
               now_ff <= req_word.timestamp; jumped_ff <= req_word.jumped;
               rv_ff <= {req_word.bin_value, 16'd0};
               rres_ff <= '0;
               rbit_ff <= 36'h4_0000_0000;
            end
            OP_ROOT_STEP: begin
               if (rv_ff >= rtry) begin
                  rv_ff <= rv_ff - rtry;
                  rres_ff <= (rres_ff >> 1) + rbit_ff;
               end else begin
                  rres_ff <= rres_ff >> 1;
               end
               rbit_ff <= rbit_ff >> 2;
            end
            OP_ROOT_ACC: begin
               if (in_range) begin
                  sum_ff <= sum_ff + SW'(rres_ff[17:0]);
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (pos_ff < PW'(MAX_BINS)) pos_ff <= pos_ff + 1'b1;
            end
            OP_DIV_LOAD: begin
               dq_ff <= sum_ff; drem_ff <= '0; dcnt_ff <= 6'(SW);
            end
            OP_DIV_STEP: begin
               if (!dtry[SW]) begin
                  drem_ff <= dtry[SW-1:0];
                  dq_ff <= {dq_ff[SW-2:0], 1'b1};
               end else begin
                  drem_ff <= {drem_ff[SW-2:0], dq_ff[SW-1]};
                  dq_ff <= {dq_ff[SW-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - 1'b1;
            end
            OP_PRIME: begin
               x_ff <= xc;
               sum_ff <= '0; cnt_ff <= '0; pos_ff <= '0;
               last_time_ff <= now_ff;
               if (!primed_ff || jumped_ff) begin
                  level_ff <= prime_from_silence ? '0 : xc;
                  base_ff  <= prime_from_silence ? '0 : xc;
                  env_ff   <= '0;
                  primed_ff <= 1'b1;
                  e_ff <= '0;
               end else if (now_ff < last_time_ff) begin
                  e_ff <= '0;
               end else if (el > 32'(MAX_ELAPSED)) begin
                  e_ff <= EW'(MAX_ELAPSED);
               end else begin
                  e_ff <= el[EW-1:0];
               end
            end
            OP_POW_LOAD: begin
               for (int i = 0; i < 3; i++) pres_ff[i] <= ONE_Q16;
               pbase_ff[0] <= {1'b0, level_retain};
               pbase_ff[1] <= {1'b0, baseline_retain};
               pbase_ff[2] <= {1'b0, onset_retain};
            end
            OP_POW_MUL: if (e_ff[0]) pres_ff[cmd.sel] <= pr;
            OP_POW_SQR: begin
               pbase_ff[cmd.sel] <= pr;
               if (cmd.sel == 2'd2) e_ff <= e_ff >> 1;
            end
            OP_UPD_MUL: begin
               pbase_ff[cmd.sel] <= pres_ff[cmd.sel];
               prod_ff[cmd.sel] <= rmul(pa, pres_ff[cmd.sel]);
            end
            OP_UPD_GAIN: grown_ff <= 25'((33'(flux) * onset_gain + 33'd128) >> 8);
            OP_FINISH: begin
               level_ff <= lvl_n; base_ff <= base_n; env_ff <= env_n;
               rsp_ff.drive <= onset_mode ? env_n :
                               ((lvl_n > ONE_Q16) ? ONE_Q16 : lvl_n);
               rsp_ff.instant <= x_ff;
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== rtl/core/beof_control.sv =====
// Controller: sequences root and accumulate for each word, and divide, powers and update for the last bin of a frame.
`timescale 1ns / 1ps
module beof_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  beof_pkg::status_type status,
   output beof_pkg::cmd_type    cmd
);
   import beof_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ROOT, S_ACC, S_DIV_LOAD, S_DIV, S_PRIME, S_POW_LOAD,
      S_POW_MUL, S_POW_SQR, S_UPD, S_GAIN, S_FINISH, S_OUT
   } state_type;

   state_type  state_ff;
   logic [1:0] sel_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      cmd.sel = sel_ff;
      case (state_ff)
         S_IDLE:     cmd.op = req_valid ? OP_ROOT_LOAD : OP_NONE;
         // hold the root and quotient once their last step is done
         S_ROOT:     cmd.op = status.root_done ? OP_NONE : OP_ROOT_STEP;
         S_ACC:      cmd.op = OP_ROOT_ACC;
         S_DIV_LOAD: cmd.op = OP_DIV_LOAD;
         S_DIV:      cmd.op = status.div_done ? OP_NONE : OP_DIV_STEP;
         S_PRIME:    cmd.op = OP_PRIME;
         S_POW_LOAD: cmd.op = OP_POW_LOAD;
         S_POW_MUL:  cmd.op = OP_POW_MUL;
         S_POW_SQR:  cmd.op = OP_POW_SQR;
         S_UPD:      cmd.op = OP_UPD_MUL;
         S_GAIN:     cmd.op = OP_UPD_GAIN;
         S_FINISH:   cmd.op = OP_FINISH;
         default:    cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE:     if (req_valid) state_ff <= S_ROOT;
            S_ROOT:     if (status.root_done) state_ff <= S_ACC;
            S_ACC:      state_ff <= status.last_bin ? S_DIV_LOAD : S_IDLE;
            S_DIV_LOAD: state_ff <= S_DIV;
            S_DIV:      if (status.div_done) state_ff <= S_PRIME;
            S_PRIME:    state_ff <= S_POW_LOAD;
            S_POW_LOAD: begin
               sel_ff <= '0;
               state_ff <= status.pow_done ? S_UPD : S_POW_MUL;
            end
            S_POW_MUL:  state_ff <= S_POW_SQR;
            S_POW_SQR: begin
               if (sel_ff == 2'd2) begin
                  sel_ff <= '0;
                  // exponent shifts on the last square
                  state_ff <= S_POW_MUL;
               end else begin
                  sel_ff <= sel_ff + 1'b1;
                  state_ff <= S_POW_MUL;
               end
            end
            S_UPD: begin
               if (sel_ff == 2'd2) begin
                  sel_ff <= '0;
                  state_ff <= S_GAIN;
               end else begin
                  sel_ff <= sel_ff + 1'b1;
               end
            end
            S_GAIN:     state_ff <= S_FINISH;
            S_FINISH:   state_ff <= S_OUT;
            S_OUT:      if (!rsp_stall) state_ff <= S_IDLE;
            default:    state_ff <= S_IDLE;
         endcase
         // leave power loop once the exponent is spent
         if (state_ff == S_POW_MUL && status.pow_done) begin
            state_ff <= S_UPD;
            sel_ff <= '0;
         end
      end
   end
endmodule

// ===== rtl/core/beof_csr.sv =====
// Configuration register file.
`timescale 1ns / 1ps
module beof_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output logic [9:0]  band_start_bin,
   output logic [9:0]  band_end_bin,
   output logic        onset_mode,
   output logic        prime_from_silence,
   output logic [15:0] level_retain,
   output logic [15:0] baseline_retain,
   output logic [15:0] onset_retain,
   output logic [15:0] onset_gain
);
   import beof_pkg::*;

   logic [9:0]  start_ff, end_ff;
   logic        mode_ff, sil_ff;
   logic [15:0] lret_ff, bret_ff, oret_ff, gain_ff;

   assign csr_ready = 1'b1;
   assign band_start_bin = start_ff;
   assign band_end_bin = end_ff;
   assign onset_mode = mode_ff;
   assign prime_from_silence = sil_ff;
   assign level_retain = lret_ff;
   assign baseline_retain = bret_ff;
   assign onset_retain = oret_ff;
   assign onset_gain = gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 10'd0; end_ff <= 10'd1023; mode_ff <= 1'b0; sil_ff <= 1'b0;
         lret_ff <= 16'd64880; bret_ff <= 16'd65340;
         oret_ff <= 16'd62000; gain_ff <= 16'd1024;
      end else if (csr_valid) begin
         case (csr_index)
            REG_BAND_START: start_ff <= csr_data[9:0];
            REG_BAND_END:   end_ff <= csr_data[9:0];
            REG_ONSET_MODE: mode_ff <= csr_data[0];
            REG_PRIME_SIL:  sil_ff <= csr_data[0];
            REG_LEVEL_RET:  lret_ff <= csr_data[15:0];
            REG_BASE_RET:   bret_ff <= csr_data[15:0];
            REG_ONSET_RET:  oret_ff <= csr_data[15:0];
            REG_ONSET_GAIN: gain_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end
endmodule
